[design/rtd_pkg.sv]
// ----------------------------------------------------------------------------
// rtd_pkg
// Shared constants, tables, conversion helpers and pipeline word types for the
// clock register snapshot decoder.
// ----------------------------------------------------------------------------
package rtd_pkg;

    // Register byte decoding
    localparam logic [7:0] BcdLowMask      = 8'h0F;
    localparam logic [7:0] HourPmMask      = 8'h80;
    localparam int unsigned StatusBinBit   = 2;
    localparam int unsigned Status24hBit   = 1;
    localparam logic [7:0] HourNoon        = 8'd12;
    localparam logic [7:0] HourMidnight    = 8'd0;

    // Year building
    localparam logic [15:0] CenturyScale   = 16'd100;
    localparam logic [15:0] BaseYear       = 16'd2000;
    localparam logic [15:0] EpochYear      = 16'd1970;

    // Time of day
    localparam int unsigned TodW           = 20;
    localparam logic [TodW-1:0] SecPerHour = 20'd3600;
    localparam logic [TodW-1:0] SecPerMin  = 20'd60;

    // Division by 100 as multiply and shift, exact for years below 43000
    localparam logic [12:0] Div100Recip    = 13'd5243;
    localparam int unsigned Div100Shift    = 19;
    // Division by 7 as multiply and shift, exact for sums below 300000
    localparam logic [17:0] Div7Recip      = 18'd149797;
    localparam int unsigned Div7Shift      = 20;
    localparam logic [15:0] DaysPerWeek    = 16'd7;

    // Day count
    localparam int unsigned DayW           = 25;
    localparam logic [23:0] DaysPerYear    = 24'd365;
    localparam logic [23:0] LeapsTo1969    = 24'd477;
    localparam logic [16:0] SecPerDay      = 17'd86400;
    localparam logic [7:0]  MonthLast      = 8'd13;
    localparam logic [7:0]  MonthMax       = 8'd12;
    localparam logic [7:0]  MonthMar       = 8'd3;
    localparam logic [3:0]  MonthFebDone   = 4'd2;

    // Snapshot of the raw clock registers
    typedef struct packed {
        logic [7:0] sec_raw;
        logic [7:0] min_raw;
        logic [7:0] hour_raw;
        logic [7:0] day_raw;
        logic [7:0] month_raw;
        logic [7:0] year_raw;
        logic [7:0] century_raw;
        logic [7:0] status_b;
    } snapshot_t;

    // Binary calendar fields after decode
    typedef struct packed {
        logic [7:0]      second;
        logic [7:0]      minute;
        logic [7:0]      hour;
        logic [7:0]      day;
        logic [7:0]      month;
        logic [15:0]     cal_year;
        logic [TodW-1:0] tod;
    } date_word_t;

    // Day count and weekday sum ahead of the final multiply
    typedef struct packed {
        date_word_t      date;
        logic [DayW-1:0] days;
        logic [15:0]     wk_sum;
        logic            month_ok;
    } count_word_t;

    // Finished result
    typedef struct packed {
        logic [7:0]  second;
        logic [7:0]  minute;
        logic [7:0]  hour;
        logic [7:0]  day;
        logic [7:0]  month;
        logic [15:0] cal_year;
        logic [2:0]  weekday;
        logic [39:0] epoch_seconds;
    } result_t;

    // Weighted BCD to binary; digits above nine keep their weight
    function automatic logic [7:0] from_bcd(input logic [7:0] v);
        logic [7:0] tens;
        tens = {4'b0000, v[7:4]};
        return (v & BcdLowMask) + (tens << 3) + (tens << 1);
    endfunction

    // Weekday offset of each month, months 1 to 12
    function automatic logic [2:0] sak_offset(input logic [3:0] m);
        logic [2:0] r;
        unique case (m)
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd2;
            4'd4:    r = 3'd5;
            4'd5:    r = 3'd0;
            4'd6:    r = 3'd3;
            4'd7:    r = 3'd5;
            4'd8:    r = 3'd1;
            4'd9:    r = 3'd4;
            4'd10:   r = 3'd6;
            4'd11:   r = 3'd2;
            4'd12:   r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // Days in the months that come before month 'last' of a common year
    function automatic logic [8:0] month_cum(input logic [3:0] last);
        logic [8:0] r;
        unique case (last)
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            4'd13:   r = 9'd365;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

[design/rtd_snapshot_if.sv]
// ----------------------------------------------------------------------------
// rtd_snapshot_if
// Valid/ready channel that carries one raw clock register snapshot.
// ----------------------------------------------------------------------------
interface rtd_snapshot_if;
    logic       valid;
    logic       ready;
    logic [7:0] sec_raw;
    logic [7:0] min_raw;
    logic [7:0] hour_raw;
    logic [7:0] day_raw;
    logic [7:0] month_raw;
    logic [7:0] year_raw;
    logic [7:0] century_raw;
    logic [7:0] status_b;

    modport source (
        output valid, sec_raw, min_raw, hour_raw, day_raw, month_raw,
               year_raw, century_raw, status_b,
        input  ready
    );

    modport sink (
        input  valid, sec_raw, min_raw, hour_raw, day_raw, month_raw,
               year_raw, century_raw, status_b,
        output ready
    );
endinterface

[design/rtd_time_if.sv]
// ----------------------------------------------------------------------------
// rtd_time_if
// Valid/ready channel that carries one decoded time word.
// ----------------------------------------------------------------------------
interface rtd_time_if;
    logic        valid;
    logic        ready;
    logic [7:0]  second;
    logic [7:0]  minute;
    logic [7:0]  hour;
    logic [7:0]  day;
    logic [7:0]  month;
    logic [15:0] cal_year;
    logic [2:0]  weekday;
    logic [39:0] epoch_seconds;

    modport source (
        output valid, second, minute, hour, day, month, cal_year, weekday,
               epoch_seconds,
        input  ready
    );

    modport sink (
        input  valid, second, minute, hour, day, month, cal_year, weekday,
               epoch_seconds,
        output ready
    );
endinterface

[design/rtc_register_time_decode.sv]
// ----------------------------------------------------------------------------
// rtc_register_time_decode
// Decodes a raw clock register snapshot into binary time, weekday and
// seconds since 1970-01-01.
//
// Channels: snap takes one word per snapshot (seconds, minutes, hours, day,
// month, year, century, status B); decoded gives one word per snapshot with
// binary fields, the four-digit year, the weekday and the epoch seconds.
// Configuration: cfg_we writes cfg_wdata into the century enable bit; write
// it only while no word is in flight.
// Pipeline: an accepted word is loaded into the first of seven register
// stages and moves on through them to decoded; one word per cycle is
// sustained while the receiver does not stall.
// Stall: while the output word waits, every stage holds and snap.ready is
// low; an empty output register or a taken output lets the whole pipeline
// advance, so bubbles ahead of the output are not squeezed out.
// Reset: clears all valid bits and the century enable bit; the pipeline is
// ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module rtc_register_time_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    rtd_snapshot_if.sink        snap,
    rtd_time_if.source          decoded
);

    logic                 century_enable_reg;
    logic                 advance;
    rtd_pkg::snapshot_t   snap_word;
    logic                 dec_valid;
    rtd_pkg::date_word_t  dec_word;
    logic                 cnt_valid;
    rtd_pkg::count_word_t cnt_word;
    logic                 res_valid;
    rtd_pkg::result_t     res_word;

    // Hold the century enable bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            century_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            century_enable_reg <= cfg_wdata;
        end
    end

    // Advance the pipeline whenever the output register is free or taken
    assign advance    = ~res_valid | decoded.ready;
    assign snap.ready = advance;

    // Gather the snapshot word
    assign snap_word.sec_raw     = snap.sec_raw;
    assign snap_word.min_raw     = snap.min_raw;
    assign snap_word.hour_raw    = snap.hour_raw;
    assign snap_word.day_raw     = snap.day_raw;
    assign snap_word.month_raw   = snap.month_raw;
    assign snap_word.year_raw    = snap.year_raw;
    assign snap_word.century_raw = snap.century_raw;
    assign snap_word.status_b    = snap.status_b;

    rtd_field_decode u_field_decode (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .century_enable (century_enable_reg),
        .in_valid       (snap.valid),
        .in_word        (snap_word),
        .out_valid      (dec_valid),
        .out_word       (dec_word)
    );

    rtd_day_count u_day_count (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (dec_valid),
        .in_word   (dec_word),
        .out_valid (cnt_valid),
        .out_word  (cnt_word)
    );

    rtd_epoch_calc u_epoch_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (cnt_valid),
        .in_word   (cnt_word),
        .out_valid (res_valid),
        .out_word  (res_word)
    );

    // Drive the result channel from the output register
    assign decoded.valid         = res_valid;
    assign decoded.second        = res_word.second;
    assign decoded.minute        = res_word.minute;
    assign decoded.hour          = res_word.hour;
    assign decoded.day           = res_word.day;
    assign decoded.month         = res_word.month;
    assign decoded.cal_year      = res_word.cal_year;
    assign decoded.weekday       = res_word.weekday;
    assign decoded.epoch_seconds = res_word.epoch_seconds;

`ifndef SYNTHESIS
    // An empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !decoded.valid |-> snap.ready)
        else $error("input blocked while output register empty");

    // The weekday remainder stays below seven
    a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
        decoded.valid |-> (decoded.weekday != 3'd7))
        else $error("weekday out of range");

    // A month outside 1 to 12 gives weekday zero
    a_bad_month_weekday: assert property (@(posedge clk) disable iff (!rst_n)
        (decoded.valid && ((decoded.month == 8'd0) || (decoded.month > 8'd12)))
        |-> (decoded.weekday == 3'd0))
        else $error("invalid month gave nonzero weekday");

    // The full year is at least one century
    a_year_floor: assert property (@(posedge clk) disable iff (!rst_n)
        decoded.valid |-> (decoded.cal_year >= 16'd100))
        else $error("full year below one century");
`endif

endmodule

[design/rtd_field_decode.sv]
// ----------------------------------------------------------------------------
// rtd_field_decode
// Stages 1 and 2: strip the PM flag, convert BCD, map 12-hour time, then
// build the full year and the seconds into the day.
// ----------------------------------------------------------------------------
module rtd_field_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                century_enable,
    input  logic                in_valid,
    input  rtd_pkg::snapshot_t  in_word,
    output logic                out_valid,
    output rtd_pkg::date_word_t out_word
);

    typedef struct packed {
        logic [7:0] second;
        logic [7:0] minute;
        logic [7:0] hour;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
        logic [7:0] century;
        logic       use_century;
    } field_word_t;

    logic                is_bcd;
    logic                is_24h;
    logic                is_pm;
    logic [7:0]          hour_strip;
    logic [7:0]          hour_bin;
    field_word_t         s1_next;
    field_word_t         s1_reg;
    logic                s1_valid_reg;
    rtd_pkg::date_word_t s2_next;
    rtd_pkg::date_word_t s2_reg;
    logic                s2_valid_reg;

    // Decode the snapshot bytes
    always_comb
    begin
        is_bcd     = ~in_word.status_b[rtd_pkg::StatusBinBit];
        is_24h     = in_word.status_b[rtd_pkg::Status24hBit];
        is_pm      = ~is_24h && ((in_word.hour_raw & rtd_pkg::HourPmMask) != 8'd0);
        hour_strip = is_pm ? (in_word.hour_raw & ~rtd_pkg::HourPmMask) : in_word.hour_raw;
        hour_bin   = is_bcd ? rtd_pkg::from_bcd(hour_strip) : hour_strip;

        s1_next.second  = is_bcd ? rtd_pkg::from_bcd(in_word.sec_raw)     : in_word.sec_raw;
        s1_next.minute  = is_bcd ? rtd_pkg::from_bcd(in_word.min_raw)     : in_word.min_raw;
        s1_next.day     = is_bcd ? rtd_pkg::from_bcd(in_word.day_raw)     : in_word.day_raw;
        s1_next.month   = is_bcd ? rtd_pkg::from_bcd(in_word.month_raw)   : in_word.month_raw;
        s1_next.year    = is_bcd ? rtd_pkg::from_bcd(in_word.year_raw)    : in_word.year_raw;
        s1_next.century = is_bcd ? rtd_pkg::from_bcd(in_word.century_raw) : in_word.century_raw;
        s1_next.use_century = century_enable && (s1_next.century != 8'd0);

        // Map 12-hour form: midnight hour reads 12, afternoon hours add 12
        s1_next.hour = hour_bin;
        if (!is_24h)
        begin
            if (hour_bin == rtd_pkg::HourNoon)
            begin
                s1_next.hour = is_pm ? rtd_pkg::HourNoon : rtd_pkg::HourMidnight;
            end
            else if (is_pm)
            begin
                s1_next.hour = hour_bin + rtd_pkg::HourNoon;
            end
        end
    end

    // Build the full year and the seconds into the day
    always_comb
    begin
        s2_next.second = s1_reg.second;
        s2_next.minute = s1_reg.minute;
        s2_next.hour   = s1_reg.hour;
        s2_next.day    = s1_reg.day;
        s2_next.month  = s1_reg.month;
        if (s1_reg.use_century)
        begin
            s2_next.cal_year = {8'd0, s1_reg.century} * rtd_pkg::CenturyScale
                             + {8'd0, s1_reg.year};
        end
        else
        begin
            s2_next.cal_year = rtd_pkg::BaseYear + {8'd0, s1_reg.year};
        end
        s2_next.tod = rtd_pkg::TodW'(s1_reg.hour) * rtd_pkg::SecPerHour
                    + rtd_pkg::TodW'(s1_reg.minute) * rtd_pkg::SecPerMin
                    + rtd_pkg::TodW'(s1_reg.second);
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_word  = s2_reg;

endmodule

[design/rtd_day_count.sv]
// ----------------------------------------------------------------------------
// rtd_day_count
// Stages 3 to 5: divide the year by 100, count leap years, then sum the days
// since the epoch and the weekday term.
// ----------------------------------------------------------------------------
module rtd_day_count (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 in_valid,
    input  rtd_pkg::date_word_t  in_word,
    output logic                 out_valid,
    output rtd_pkg::count_word_t out_word
);

    typedef struct packed {
        rtd_pkg::date_word_t date;
        logic [15:0]         year_m1;
        logic [8:0]          cent_y;
        logic [8:0]          cent_m1;
    } div_word_t;

    typedef struct packed {
        rtd_pkg::date_word_t date;
        logic                leap;
        logic                after_epoch;
        logic [14:0]         year_off;
        logic [12:0]         leaps_m1;
        logic [15:0]         wk_year;
        logic [12:0]         wk_leaps;
    } leap_word_t;

    logic [28:0]          prod_y;
    logic [28:0]          prod_m1;
    div_word_t            s3_next;
    div_word_t            s3_reg;
    logic                 s3_valid_reg;
    logic [12:0]          leaps_y;
    logic                 early_month;
    leap_word_t           s4_next;
    leap_word_t           s4_reg;
    logic                 s4_valid_reg;
    logic [23:0]          year_days;
    logic [3:0]           month_last;
    logic                 leap_day;
    rtd_pkg::count_word_t s5_next;
    rtd_pkg::count_word_t s5_reg;
    logic                 s5_valid_reg;

    // Divide the year and the year before by 100
    always_comb
    begin
        s3_next.date    = in_word;
        s3_next.year_m1 = in_word.cal_year - 16'd1;
        prod_y  = 29'(in_word.cal_year) * 29'(rtd_pkg::Div100Recip);
        prod_m1 = 29'(s3_next.year_m1) * 29'(rtd_pkg::Div100Recip);
        s3_next.cent_y  = 9'(prod_y >> rtd_pkg::Div100Shift);
        s3_next.cent_m1 = 9'(prod_m1 >> rtd_pkg::Div100Shift);
    end

    // Count leap years up to each year: n/4 - n/100 + n/400
    always_comb
    begin
        leaps_y = 13'({2'b00, s3_reg.date.cal_year[15:2]} - {7'd0, s3_reg.cent_y}
                      + {9'd0, s3_reg.cent_y[8:2]});
        s4_next.leaps_m1 = 13'({2'b00, s3_reg.year_m1[15:2]} - {7'd0, s3_reg.cent_m1}
                               + {9'd0, s3_reg.cent_m1[8:2]});
        s4_next.date        = s3_reg.date;
        s4_next.leap        = leaps_y != s4_next.leaps_m1;
        s4_next.after_epoch = s3_reg.date.cal_year > rtd_pkg::EpochYear;
        s4_next.year_off    = 15'(s3_reg.date.cal_year - rtd_pkg::EpochYear);
        // January and February count in the previous year
        early_month      = s3_reg.date.month < rtd_pkg::MonthMar;
        s4_next.wk_year  = early_month ? s3_reg.year_m1 : s3_reg.date.cal_year;
        s4_next.wk_leaps = early_month ? s4_next.leaps_m1 : leaps_y;
    end

    // Sum the days since the epoch and the weekday term
    always_comb
    begin
        if (s4_reg.after_epoch)
        begin
            year_days = 24'(s4_reg.year_off) * rtd_pkg::DaysPerYear
                      + 24'(s4_reg.leaps_m1) - rtd_pkg::LeapsTo1969;
        end
        else
        begin
            year_days = 24'd0;
        end
        month_last = (s4_reg.date.month > rtd_pkg::MonthLast)
                   ? rtd_pkg::MonthLast[3:0] : s4_reg.date.month[3:0];
        leap_day   = s4_reg.leap && (month_last > rtd_pkg::MonthFebDone);

        s5_next.date = s4_reg.date;
        // A day of zero before the epoch wraps below zero
        s5_next.days = rtd_pkg::DayW'(year_days)
                     + rtd_pkg::DayW'(rtd_pkg::month_cum(month_last))
                     + rtd_pkg::DayW'(leap_day)
                     + rtd_pkg::DayW'(s4_reg.date.day)
                     - rtd_pkg::DayW'(1);
        s5_next.month_ok = (s4_reg.date.month != 8'd0)
                        && (s4_reg.date.month <= rtd_pkg::MonthMax);
        s5_next.wk_sum = s4_reg.wk_year
                       + 16'(s4_reg.wk_leaps)
                       + 16'(rtd_pkg::sak_offset(s4_reg.date.month[3:0]))
                       + 16'(s4_reg.date.day);
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s3_valid_reg <= in_valid;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_word  = s5_reg;

endmodule

[design/rtd_epoch_calc.sv]
// ----------------------------------------------------------------------------
// rtd_epoch_calc
// Stages 6 and 7: scale the day count to seconds and take the weekday
// quotient, then add the time of day and finish the weekday remainder.
// ----------------------------------------------------------------------------
module rtd_epoch_calc (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 in_valid,
    input  rtd_pkg::count_word_t in_word,
    output logic                 out_valid,
    output rtd_pkg::result_t     out_word
);

    typedef struct packed {
        rtd_pkg::date_word_t date;
        logic [39:0]         day_secs;
        logic [15:0]         wk_sum;
        logic [12:0]         wk_quot;
        logic                month_ok;
    } scale_word_t;

    logic signed [42:0] day_prod;
    logic [33:0]        wk_prod;
    scale_word_t        s6_next;
    scale_word_t        s6_reg;
    logic               s6_valid_reg;
    logic [15:0]        wk_rem;
    rtd_pkg::result_t   s7_next;
    rtd_pkg::result_t   s7_reg;
    logic               s7_valid_reg;

    // Scale days to seconds, divide the weekday sum by 7
    always_comb
    begin
        day_prod = 43'($signed(in_word.days)) * 43'($signed({1'b0, rtd_pkg::SecPerDay}));
        wk_prod  = 34'(in_word.wk_sum) * 34'(rtd_pkg::Div7Recip);
        s6_next.date     = in_word.date;
        s6_next.day_secs = day_prod[39:0];
        s6_next.wk_sum   = in_word.wk_sum;
        s6_next.wk_quot  = 13'(wk_prod >> rtd_pkg::Div7Shift);
        s6_next.month_ok = in_word.month_ok;
    end

    // Add the time of day, take the weekday remainder
    always_comb
    begin
        wk_rem = s6_reg.wk_sum - 16'(s6_reg.wk_quot) * rtd_pkg::DaysPerWeek;
        s7_next.second        = s6_reg.date.second;
        s7_next.minute        = s6_reg.date.minute;
        s7_next.hour          = s6_reg.date.hour;
        s7_next.day           = s6_reg.date.day;
        s7_next.month         = s6_reg.date.month;
        s7_next.cal_year      = s6_reg.date.cal_year;
        s7_next.weekday       = s6_reg.month_ok ? wk_rem[2:0] : 3'd0;
        s7_next.epoch_seconds = s6_reg.day_secs + 40'(s6_reg.date.tod);
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s6_valid_reg <= in_valid;
            s7_valid_reg <= s6_valid_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s6_reg <= s6_next;
            s7_reg <= s7_next;
        end
    end

    assign out_valid = s7_valid_reg;
    assign out_word  = s7_reg;

endmodule

[test/rtd_time_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtd_time_checker
// Watches the snapshot and decoded-time channels of the register time decoder,
// works out the decoded word for every accepted snapshot and compares each
// decoded word, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module rtd_time_checker (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cfg_we,
    input  logic    cfg_wdata,
    rtd_snapshot_if snap,
    rtd_time_if     decoded,
    output int      errors,
    output int      outstanding,
    output int      words_checked
);

    localparam int unsigned MonthOffset [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
    localparam int unsigned MonthDays [13] =
        '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    rtd_pkg::result_t time_due [$];
    logic             century_on = 1'b0;

    initial
    begin
        errors        = 0;
        outstanding   = 0;
        words_checked = 0;
    end

    // Weighted BCD: a digit above nine keeps its weight
    function automatic logic [7:0] bcd_value(input logic [7:0] v);
        return {4'd0, v[3:0]} + {4'd0, v[7:4]} * 8'd10;
    endfunction

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned leap_count(input int unsigned n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    // Decode one raw snapshot into the time word the block should give
    function automatic rtd_pkg::result_t decode_snapshot(input rtd_pkg::snapshot_t s,
                                                         input logic cen);
        logic [7:0]       sec, mins, hr, dy, mo, yr, ce;
        bit               bcd, h24, pm;
        int unsigned      full, wy, wd, mn, last;
        logic [63:0]      days, total;
        rtd_pkg::result_t r;
        sec  = s.sec_raw;
        mins = s.min_raw;
        hr   = s.hour_raw;
        dy   = s.day_raw;
        mo   = s.month_raw;
        yr   = s.year_raw;
        ce   = s.century_raw;
        bcd  = !s.status_b[2];
        h24  = s.status_b[1];
        pm   = 1'b0;

        // Strip the PM flag before any BCD conversion
        if (!h24 && hr[7])
        begin
            pm = 1'b1;
            hr = hr & 8'h7F;
        end
        if (bcd)
        begin
            sec  = bcd_value(sec);
            mins = bcd_value(mins);
            hr   = bcd_value(hr);
            dy   = bcd_value(dy);
            mo   = bcd_value(mo);
            yr   = bcd_value(yr);
            ce   = bcd_value(ce);
        end
        // Map 12-hour form onto 24-hour form
        if (!h24)
        begin
            if (hr == 8'd12)
                hr = pm ? 8'd12 : 8'd0;
            else if (pm)
                hr = hr + 8'd12;
        end

        if (cen && ce != 8'd0)
            full = int'(ce) * 100 + int'(yr);
        else
            full = 2000 + int'(yr);

        // Weekday; an invalid month gives Sunday
        if (mo < 8'd1 || mo > 8'd12)
            wd = 0;
        else
        begin
            wy = full;
            if (mo < 8'd3)
                wy = wy - 1;
            wd = (wy + wy / 4 - wy / 100 + wy / 400 + MonthOffset[int'(mo) - 1]
                  + int'(dy)) % 7;
        end

        // Day count from whole years, then whole months, then the day itself
        days = 64'd0;
        if (full > 1970)
            days = 64'(365 * (full - 1970)) + 64'(leap_count(full - 1) - leap_count(1969));
        last = (mo > 8'd13) ? 13 : int'(mo);
        for (mn = 1; mn < last; mn++)
        begin
            days = days + 64'(MonthDays[mn]);
            if (mn == 2 && leap_year(full))
                days = days + 64'd1;
        end
        days  = days + 64'(dy) - 64'd1;
        total = days * 64'd86400 + 64'(hr) * 64'd3600 + 64'(mins) * 64'd60 + 64'(sec);

        r.second        = sec;
        r.minute        = mins;
        r.hour          = hr;
        r.day           = dy;
        r.month         = mo;
        r.cal_year      = full[15:0];
        r.weekday       = wd[2:0];
        r.epoch_seconds = total[39:0];
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [39:0] want,
                                 input logic [39:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // Check outgoing words first, then queue the prediction for an incoming one
    always @(posedge clk)
    begin
        rtd_pkg::result_t   want;
        rtd_pkg::snapshot_t word;
        if (!rst_n)
            century_on = 1'b0;
        else
        begin
            if (decoded.valid && decoded.ready)
            begin
                if (time_due.size() == 0)
                begin
                    $error("decoded word with no snapshot outstanding");
                    errors++;
                end
                else
                begin
                    want = time_due.pop_front();
                    compare_field("second", 40'(want.second), 40'(decoded.second));
                    compare_field("minute", 40'(want.minute), 40'(decoded.minute));
                    compare_field("hour", 40'(want.hour), 40'(decoded.hour));
                    compare_field("day", 40'(want.day), 40'(decoded.day));
                    compare_field("month", 40'(want.month), 40'(decoded.month));
                    compare_field("cal_year", 40'(want.cal_year), 40'(decoded.cal_year));
                    compare_field("weekday", 40'(want.weekday), 40'(decoded.weekday));
                    compare_field("epoch_seconds", want.epoch_seconds,
                                  decoded.epoch_seconds);
                end
                words_checked++;
            end
            if (snap.valid && snap.ready)
            begin
                word.sec_raw     = snap.sec_raw;
                word.min_raw     = snap.min_raw;
                word.hour_raw    = snap.hour_raw;
                word.day_raw     = snap.day_raw;
                word.month_raw   = snap.month_raw;
                word.year_raw    = snap.year_raw;
                word.century_raw = snap.century_raw;
                word.status_b    = snap.status_b;
                time_due.push_back(decode_snapshot(word, century_on));
            end
            if (cfg_we)
                century_on = cfg_wdata;
        end
        outstanding = time_due.size();
    end

endmodule

[test/rtc_register_time_decode_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtc_register_time_decode_test
// Drives the register time decoder with directed corner snapshots and then
// random snapshots under four handshake regimes, with the century register
// switched on and off between phases; a checker beside the block predicts
// and compares every decoded word.
// ----------------------------------------------------------------------------
module rtc_register_time_decode_test;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   gap_pct   = 0;
    int   stall_pct = 0;
    int   sent_count = 0;
    int   errors;
    int   outstanding;
    int   words_checked;

    rtd_snapshot_if snap ();
    rtd_time_if     decoded ();

    rtc_register_time_decode dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .snap      (snap),
        .decoded   (decoded)
    );

    rtd_time_checker time_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .snap          (snap),
        .decoded       (decoded),
        .errors        (errors),
        .outstanding   (outstanding),
        .words_checked (words_checked)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: stall at random, changing only at the falling edge
    initial
    begin
        decoded.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            decoded.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic rtd_pkg::snapshot_t mk(input logic [7:0] s, input logic [7:0] mi,
                                              input logic [7:0] h, input logic [7:0] d,
                                              input logic [7:0] mo, input logic [7:0] y,
                                              input logic [7:0] c, input logic [7:0] sb);
        rtd_pkg::snapshot_t r;
        r.sec_raw     = s;
        r.min_raw     = mi;
        r.hour_raw    = h;
        r.day_raw     = d;
        r.month_raw   = mo;
        r.year_raw    = y;
        r.century_raw = c;
        r.status_b    = sb;
        return r;
    endfunction

    function automatic logic [7:0] encode(input int unsigned v, input bit bin);
        return bin ? 8'(v) : {4'(v / 10), 4'(v % 10)};
    endfunction

    // Mostly a plausible clock reading, sometimes with one byte spoilt, else noise
    function automatic rtd_pkg::snapshot_t random_snapshot();
        logic [7:0]  sb, hr, ce;
        logic [63:0] flat;
        bit          bin;
        int          pick, k;
        pick = $urandom_range(99);
        if (pick >= 85)
            return rtd_pkg::snapshot_t'({$urandom, $urandom});
        sb  = 8'($urandom);
        bin = sb[2];
        if (sb[1])
            hr = encode($urandom_range(23), bin);
        else
            hr = encode($urandom_range(1, 12), bin) | ($urandom_range(1) ? 8'h80 : 8'h00);
        case ($urandom_range(3))
            0:       ce = encode(19, bin);
            1:       ce = encode(20, bin);
            2:       ce = encode(21, bin);
            default: ce = encode($urandom_range(99), bin);
        endcase
        flat = mk(encode($urandom_range(59), bin), encode($urandom_range(59), bin), hr,
                  encode($urandom_range(1, 31), bin), encode($urandom_range(1, 12), bin),
                  encode($urandom_range(99), bin), ce, sb);
        if (pick >= 70)
        begin
            k = $urandom_range(7);
            flat[k * 8 +: 8] = 8'($urandom);
        end
        return rtd_pkg::snapshot_t'(flat);
    endfunction

    // Offer one word, idling first at random, and hold it until taken
    task automatic send_snapshot(input rtd_pkg::snapshot_t s);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            snap.valid <= 1'b0;
            @(negedge clk);
        end
        snap.valid       <= 1'b1;
        snap.sec_raw     <= s.sec_raw;
        snap.min_raw     <= s.min_raw;
        snap.hour_raw    <= s.hour_raw;
        snap.day_raw     <= s.day_raw;
        snap.month_raw   <= s.month_raw;
        snap.year_raw    <= s.year_raw;
        snap.century_raw <= s.century_raw;
        snap.status_b    <= s.status_b;
        do
            @(posedge clk);
        while (!snap.ready);
        sent_count++;
    endtask

    // Drop valid and wait until every predicted word has come out
    task automatic settle();
        @(negedge clk);
        snap.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_century(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int phase;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = 1'b0;
        snap.valid       = 1'b0;
        snap.sec_raw     = 8'h00;
        snap.min_raw     = 8'h00;
        snap.hour_raw    = 8'h00;
        snap.day_raw     = 8'h00;
        snap.month_raw   = 8'h00;
        snap.year_raw    = 8'h00;
        snap.century_raw = 8'h00;
        snap.status_b    = 8'h00;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Century register at its reset value: decoding corners
        send_snapshot(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_snapshot(mk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_snapshot(mk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00));
        send_snapshot(mk(8'h00, 8'h00, 8'h12, 8'h01, 8'h01, 8'h00, 8'h20, 8'h00));
        send_snapshot(mk(8'h00, 8'h00, 8'h92, 8'h01, 8'h01, 8'h00, 8'h20, 8'h00));
        send_snapshot(mk(8'h30, 8'h45, 8'h81, 8'h15, 8'h06, 8'h24, 8'h20, 8'h00));
        send_snapshot(mk(8'h00, 8'h00, 8'h8B, 8'h1F, 8'h0C, 8'h63, 8'h00, 8'h04));
        send_snapshot(mk(8'h00, 8'h00, 8'h0C, 8'h01, 8'h01, 8'h00, 8'h00, 8'h04));
        send_snapshot(mk(8'h00, 8'h00, 8'h80, 8'h01, 8'h01, 8'h00, 8'h00, 8'h02));
        send_snapshot(mk(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h00, 8'h02));
        send_snapshot(mk(8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h00, 8'h00, 8'h02));
        send_snapshot(mk(8'h00, 8'h00, 8'h00, 8'h01, 8'h99, 8'h00, 8'h00, 8'h02));
        send_snapshot(mk(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00, 8'h00, 8'h02));
        send_snapshot(mk(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h00, 8'h02));
        send_snapshot(mk(8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h06));
        settle();
        write_century(1'b1);

        // Century register on: year building, early years and wrap round
        send_snapshot(mk(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70, 8'h19, 8'h02));
        send_snapshot(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h70, 8'h19, 8'h02));
        send_snapshot(mk(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'h01, 8'h02));
        send_snapshot(mk(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h21, 8'h02));
        send_snapshot(mk(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h24, 8'h02));
        send_snapshot(mk(8'h00, 8'h00, 8'h00, 8'h15, 8'h06, 8'h23, 8'h00, 8'h02));
        send_snapshot(mk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_snapshot(mk(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h99, 8'h02));
        settle();

        // Random words: free flow, slow sender, slow receiver, both slightly slow
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 81; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 81; end
                default: begin gap_pct = 11; stall_pct = 11; end
            endcase
            write_century(phase[0] ? 1'b1 : 1'b0);
            repeat (132) send_snapshot(random_snapshot());
            settle();
        end

        $display("%0d snapshots sent, %0d decoded words checked", sent_count, words_checked);
        $display("four handshake regimes, century register switched on and off");
        if (errors == 0 && outstanding == 0)
            $display("rtc_register_time_decode verification clean");
        else
            $display("rtc_register_time_decode verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4000000;
        $display("rtc_register_time_decode verification failed");
        $finish;
    end

endmodule
